[hw/rtl/key_index_merge_sorter_top_macros.svh]
// Assertion macros used by the checker file of the key/index merge sorter.
`ifndef KEY_INDEX_MERGE_SORTER_TOP_MACROS_SVH
`define KEY_INDEX_MERGE_SORTER_TOP_MACROS_SVH

// The condition must never be true outside reset.
`define KIMS_ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
    else $error("kims: forbidden condition seen");

// When the antecedent holds, the consequent must hold in the next cycle.
`define KIMS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("kims: expected follow-up behavior not seen");

`endif

[hw/rtl/kims_pkg.sv]
// Shared types and constants of the key/index merge sorter.
`default_nettype none
package kims_pkg;

  localparam int KEY_W  = 32;
  localparam int IDX_W  = 16;
  localparam int DATA_W = 48;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_EVAL,
    ST_POP,
    ST_MRD,
    ST_MWR,
    ST_COPY,
    ST_DRAIN,
    ST_ORD,
    ST_OLD,
    ST_OHOLD
  } state_t;

  typedef enum logic [1:0] {
    STG_FRESH,
    STG_LEFT,
    STG_BOTH
  } stage_t;

  typedef struct packed {
    logic load_wr;
    logic stk_init;
    logic push_left;
    logic push_right;
    logic pop;
    logic mrg_init;
    logic mrg_step;
    logic cp_step;
    logic out_sel;
    logic out_init;
    logic out_load;
    logic out_next;
    logic batch_clr;
  } cmd_t;

  typedef struct packed {
    logic   top_small;
    stage_t top_stage;
    logic   stk_bottom;
    logic   mrg_last;
    logic   cp_last;
    logic   out_beat;
    logic   out_final;
  } sts_t;

endpackage
`default_nettype wire

[hw/rtl/key_index_merge_sorter_top.sv]
// Top level of the key/index merge sorter: controller plus datapath.
`default_nettype none
// Batch sorter for (key, index) records. Records stream in one beat per cycle and are stored
// in arrival order; the beat with in_tlast set closes the batch, and up to MAX_ITEMS records
// are kept (records beyond that are dropped and every result of the batch then carries the
// overflow flag in out_tuser). The batch is then sorted by signed Q16.16 key, ascending, with a
// top-down merge sort that splits each range at the floor midpoint; on equal keys the record
// from the upper half comes out first. The recursion runs on a small range stack in the
// datapath. Each merge step first reads both halves from the record store into registers,
// then compares them and writes the chosen record to the scratch store; the copy back then
// moves the merged range from the scratch store to the record store. Results are then read
// one at a time, loaded into the output register and held until the sink takes them. No new
// beat is accepted between the last input beat of a batch and the last result beat, so
// in_tready and out_tvalid are never high together.
module key_index_merge_sorter_top #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // in_tdata: [31:0] sort_key, [47:32] item_index.
  input  wire logic [kims_pkg::DATA_W-1:0] in_tdata,
  input  wire logic                        in_tlast,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // out_tdata: [31:0] out_key, [47:32] out_index.
  output logic [kims_pkg::DATA_W-1:0]      out_tdata,
  output logic                             out_tlast,
  // out_tuser: [0] overflow.
  output logic                             out_tuser
);
  import kims_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller walks load, range evaluation, merge, copy back and output.
  kims_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds both record stores, the range stack and the output register.
  kims_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

[hw/rtl/kims_ctrl.sv]
// Sequencing state machine of the key/index merge sorter.
`default_nettype none
module kims_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  wire logic          in_tlast,
  output logic               in_tready,
  input  kims_pkg::sts_t     sts,
  output kims_pkg::cmd_t     cmd
);
  import kims_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_tvalid && in_tlast) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts.top_small) begin
          state_nxt = ST_POP;
        end else begin
          case (sts.top_stage)
            STG_FRESH: state_nxt = ST_EVAL;
            STG_LEFT:  state_nxt = ST_EVAL;
            STG_BOTH:  state_nxt = ST_MRD;
            default:   state_nxt = ST_POP;
          endcase
        end
      end
      ST_POP: begin
        state_nxt = sts.stk_bottom ? ST_ORD : ST_EVAL;
      end
      ST_MRD:   state_nxt = ST_MWR;
      ST_MWR: begin
        state_nxt = sts.mrg_last ? ST_COPY : ST_MRD;
      end
      ST_COPY: begin
        if (sts.cp_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_POP;
      ST_ORD:   state_nxt = ST_OLD;
      ST_OLD:   state_nxt = ST_OHOLD;
      ST_OHOLD: begin
        if (sts.out_beat) state_nxt = sts.out_final ? ST_LOAD : ST_ORD;
      end
      default:  state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_tready    = 1'b1;
        cmd.load_wr  = in_tvalid;
        cmd.stk_init = in_tvalid && in_tlast;
      end
      ST_EVAL: begin
        if (!sts.top_small) begin
          case (sts.top_stage)
            STG_FRESH: cmd.push_left  = 1'b1;
            STG_LEFT:  cmd.push_right = 1'b1;
            STG_BOTH:  cmd.mrg_init   = 1'b1;
            default:   cmd.pop        = 1'b0;
          endcase
        end
      end
      ST_POP: begin
        cmd.pop      = !sts.stk_bottom;
        cmd.out_init = sts.stk_bottom;
      end
      ST_MRD:   cmd.mrg_step = 1'b0;
      ST_MWR:   cmd.mrg_step = 1'b1;
      ST_COPY:  cmd.cp_step  = 1'b1;
      ST_DRAIN: cmd.cp_step  = 1'b0;
      ST_ORD:   cmd.out_sel  = 1'b1;
      ST_OLD:   cmd.out_load = 1'b1;
      ST_OHOLD: begin
        cmd.out_next  = sts.out_beat && !sts.out_final;
        cmd.batch_clr = sts.out_beat && sts.out_final;
      end
      default:  cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/kims_dp.sv]
// Datapath of the key/index merge sorter: record stores, range stack, merge and output.
`default_nettype none
module kims_dp #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [kims_pkg::DATA_W-1:0] in_tdata,
  input  kims_pkg::cmd_t                   cmd,
  output kims_pkg::sts_t                   sts,
  input  wire logic                        out_tready,
  output logic                             out_tvalid,
  output logic [kims_pkg::DATA_W-1:0]      out_tdata,
  output logic                             out_tlast,
  output logic                             out_tuser
);
  import kims_pkg::*;

  localparam int CW    = $clog2(MAX_ITEMS + 1);
  localparam int AW    = $clog2(MAX_ITEMS);
  localparam int DEPTH = $clog2(MAX_ITEMS) + 1;
  localparam int SPW   = $clog2(DEPTH);

  // Record stores: key in the low bits, index above it.
  logic [DATA_W-1:0] rec_mem [MAX_ITEMS];
  logic [DATA_W-1:0] scr_mem [MAX_ITEMS];

  logic [CW-1:0]  count_r;
  logic           drop_r;
  logic           room;
  logic [CW-1:0]  count_new;

  // Range stack.
  logic [CW-1:0]  stk_lo [DEPTH];
  logic [CW-1:0]  stk_hi [DEPTH];
  stage_t         stk_st [DEPTH];
  logic [SPW-1:0] sp_r;
  logic [SPW-1:0] sp_up;
  logic [CW-1:0]  top_lo, top_hi, top_mid;
  logic [CW:0]    top_sum;

  // Merge and copy pointers.
  logic [CW-1:0]  a_r, b_r, w_r, mid_r, hi_r, cp_r, k_r;
  logic [DATA_W-1:0] ra_q, rb_q, sc_q;
  logic           cpw_vld_r;
  logic [AW-1:0]  cpw_addr_r;
  logic [CW-1:0]  rda;
  logic           take_a;

  logic           st_we;
  logic [AW-1:0]  st_wa;
  logic [DATA_W-1:0] st_wd;

  logic [DATA_W-1:0] out_rec_r;
  logic           out_last_r, out_ovf_r, out_valid_r;

  assign room      = count_r < CW'(MAX_ITEMS);
  assign count_new = count_r + CW'(room);

  assign top_lo  = stk_lo[sp_r];
  assign top_hi  = stk_hi[sp_r];
  assign top_sum = {1'b0, top_lo} + {1'b0, top_hi};
  assign top_mid = top_sum[CW:1];
  assign sp_up   = sp_r + 1'b1;

  assign sts.top_small  = (top_lo + 1'b1) >= top_hi;
  assign sts.top_stage  = stk_st[sp_r];
  assign sts.stk_bottom = (sp_r == '0);
  assign sts.mrg_last   = (w_r + 1'b1) == hi_r;
  assign sts.cp_last    = (cp_r + 1'b1) == hi_r;
  assign sts.out_beat   = out_valid_r && out_tready;
  assign sts.out_final  = out_last_r;

  // On equal keys the second half goes first.
  assign take_a = (b_r >= hi_r) ||
                  ((a_r < mid_r) &&
                   ($signed(ra_q[KEY_W-1:0]) < $signed(rb_q[KEY_W-1:0])));

  assign rda   = cmd.out_sel ? k_r : a_r;
  assign st_we = (cmd.load_wr && room) || cpw_vld_r;
  assign st_wa = cmd.load_wr ? count_r[AW-1:0] : cpw_addr_r;
  assign st_wd = cmd.load_wr ? in_tdata : sc_q;

  always_ff @(posedge clk) begin
    if (st_we) rec_mem[st_wa] <= st_wd;
    ra_q <= rec_mem[rda[AW-1:0]];
    rb_q <= rec_mem[b_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.mrg_step) scr_mem[w_r[AW-1:0]] <= take_a ? ra_q : rb_q;
    sc_q <= scr_mem[cp_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      drop_r      <= 1'b0;
      sp_r        <= '0;
      cpw_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cpw_vld_r <= cmd.cp_step;
      if (cmd.load_wr) begin
        count_r <= count_new;
        if (!room) drop_r <= 1'b1;
      end
      if (cmd.batch_clr) begin
        count_r <= '0;
        drop_r  <= 1'b0;
      end
      if (cmd.stk_init) sp_r <= '0;
      if (cmd.push_left || cmd.push_right) sp_r <= sp_up;
      if (cmd.pop) sp_r <= sp_r - 1'b1;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (sts.out_beat) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stk_init) begin
      stk_lo[0] <= '0;
      stk_hi[0] <= count_new;
      stk_st[0] <= STG_FRESH;
    end
    if (cmd.push_left) begin
      stk_st[sp_r]  <= STG_LEFT;
      stk_lo[sp_up] <= top_lo;
      stk_hi[sp_up] <= top_mid;
      stk_st[sp_up] <= STG_FRESH;
    end
    if (cmd.push_right) begin
      stk_st[sp_r]  <= STG_BOTH;
      stk_lo[sp_up] <= top_mid;
      stk_hi[sp_up] <= top_hi;
      stk_st[sp_up] <= STG_FRESH;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mrg_init) begin
      a_r   <= top_lo;
      b_r   <= top_mid;
      w_r   <= top_lo;
      cp_r  <= top_lo;
      mid_r <= top_mid;
      hi_r  <= top_hi;
    end
    if (cmd.mrg_step) begin
      w_r <= w_r + 1'b1;
      if (take_a) a_r <= a_r + 1'b1;
      else        b_r <= b_r + 1'b1;
    end
    if (cmd.cp_step) begin
      cp_r       <= cp_r + 1'b1;
      cpw_addr_r <= cp_r[AW-1:0];
    end
    if (cmd.out_init) k_r <= '0;
    if (cmd.out_next) k_r <= k_r + 1'b1;
    if (cmd.out_load) begin
      out_rec_r  <= ra_q;
      out_last_r <= (k_r + 1'b1) == count_r;
      out_ovf_r  <= drop_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_rec_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule
`default_nettype wire

[hw/rtl/kims_chk.sv]
// Port-level checker of the key/index merge sorter and its bind to the top level.
`default_nettype none
`include "key_index_merge_sorter_top_macros.svh"
module kims_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tvalid,
  input wire logic                        in_tready,
  input wire logic [kims_pkg::DATA_W-1:0] in_tdata,
  input wire logic                        in_tlast,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [kims_pkg::DATA_W-1:0] out_tdata,
  input wire logic                        out_tlast,
  input wire logic                        out_tuser
);
  import kims_pkg::*;

  logic [DATA_W-1:0] in_seen;
  assign in_seen = in_tdata;

  // Loading and emitting never overlap.
  `KIMS_ASSERT_NEVER(a_no_overlap, clk, rst_n, in_tready && out_tvalid)

  // A stalled result holds its payload.
  `KIMS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))

  // Closing a batch stops intake and nothing is shown yet while sorting starts.
  `KIMS_ASSERT_NEXT(a_sort_after_last, clk, rst_n, in_tvalid && in_tready && in_tlast && (in_seen == in_tdata), !in_tready && !out_tvalid)

  // Each result beat is followed by a cycle with no valid result.
  `KIMS_ASSERT_NEXT(a_gap_after_out, clk, rst_n, out_tvalid && out_tready, !out_tvalid)

endmodule

bind key_index_merge_sorter_top kims_chk u_kims_chk (.*);
`default_nettype wire
